// ===== src/checked_int_alu_fold_macros.svh =====
// assertion helpers used by checked_int_alu_fold.sv
`ifndef CHECKED_INT_ALU_FOLD_MACROS_SVH
`define CHECKED_INT_ALU_FOLD_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define CKALU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define CKALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ckalu_pkg.sv =====
// ----------------------------------------------------------------------------
// ckalu_pkg
// Codes, record types and width helpers for the checked integer alu.
// ----------------------------------------------------------------------------
`default_nettype none

package ckalu_pkg;

  localparam logic [3:0] OP_EQ  = 4'd0;
  localparam logic [3:0] OP_NE  = 4'd1;
  localparam logic [3:0] OP_LT  = 4'd2;
  localparam logic [3:0] OP_LE  = 4'd3;
  localparam logic [3:0] OP_GT  = 4'd4;
  localparam logic [3:0] OP_GE  = 4'd5;
  localparam logic [3:0] OP_AND = 4'd6;
  localparam logic [3:0] OP_OR  = 4'd7;
  localparam logic [3:0] OP_NOT = 4'd8;
  localparam logic [3:0] OP_ADD = 4'd9;
  localparam logic [3:0] OP_SUB = 4'd10;
  localparam logic [3:0] OP_MUL = 4'd11;
  localparam logic [3:0] OP_DIV = 4'd12;

  localparam logic [2:0] TY_BOOL = 3'd0;
  localparam logic [2:0] TY_I8   = 3'd1;
  localparam logic [2:0] TY_I16  = 3'd2;
  localparam logic [2:0] TY_I32  = 3'd3;
  localparam logic [2:0] TY_I64  = 3'd4;

  localparam int DIV_STAGES = 64;

  // result record carried down the pipeline
  typedef struct packed {
    logic        folded;
    logic [63:0] value;
    logic        is_bool;
    logic        ovf;
    logic        div_go;
    logic        q_neg;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [63:0] rem;
    logic [63:0] dvd;
    logic [63:0] dvs;
  } div_stage_t;

  typedef struct packed {
    logic        folded;
    logic [63:0] value;
    logic        is_bool;
    logic        ovf;
  } result_t;

  function automatic logic [63:0] sext(input logic [63:0] raw, input logic [2:0] ty);
    logic [63:0] r;
    case (ty)
      TY_BOOL: r = {63'b0, raw[0]};
      TY_I8:   r = {{56{raw[7]}}, raw[7:0]};
      TY_I16:  r = {{48{raw[15]}}, raw[15:0]};
      TY_I32:  r = {{32{raw[31]}}, raw[31:0]};
      default: r = raw;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] min_of(input logic [2:0] ty);
    logic [63:0] r;
    case (ty)
      TY_I8:   r = {{57{1'b1}}, 7'b0};
      TY_I16:  r = {{49{1'b1}}, 15'b0};
      TY_I32:  r = {{33{1'b1}}, 31'b0};
      default: r = {1'b1, 63'b0};
    endcase
    return r;
  endfunction

  // true when the signed value is representable at the type's width
  function automatic logic fits(input logic [127:0] p, input logic [2:0] ty);
    logic r;
    case (ty)
      TY_I8:   r = (&p[127:7])  | ~(|p[127:7]);
      TY_I16:  r = (&p[127:15]) | ~(|p[127:15]);
      TY_I32:  r = (&p[127:31]) | ~(|p[127:31]);
      TY_I64:  r = (&p[127:63]) | ~(|p[127:63]);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/checked_int_alu_fold.sv =====
// ----------------------------------------------------------------------------
// checked_int_alu_fold
// Overflow-checked integer alu: compare, boolean logic and checked add,
// subtract, multiply and divide at 8, 16, 32 or 64 bits, with a fold flag.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: req_valid / req_stall with operation, value_type,
//   lhs_value and rhs_value. A transaction completes on a clock edge with
//   req_valid high and req_stall low.
//   Response channel: rsp_valid / rsp_stall with folded, result_value,
//   result_is_boolean and overflow, one response per request, in order.
//   From request to response an item passes four front stages,
//   64 divider stages (one quotient bit each), one select stage and the
//   output register. Every operation takes the same path.
//   Throughput is one transaction per cycle while rsp_stall stays low.
//   A stalled response is held on the output register; one more item is
//   caught in a skid register, after which req_stall goes high and the
//   whole pipeline freezes until the response side drains.
//   Synchronous reset empties the pipeline, the output and the skid
//   register; nothing else is kept between transactions.
// ----------------------------------------------------------------------------
`default_nettype none

`include "checked_int_alu_fold_macros.svh"

module checked_int_alu_fold (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output      logic        req_stall,
  input  wire logic [3:0]  operation,
  input  wire logic [2:0]  value_type,
  input  wire logic [63:0] lhs_value,
  input  wire logic [63:0] rhs_value,
  output      logic        rsp_valid,
  input  wire logic        rsp_stall,
  output      logic        folded,
  output      logic [63:0] result_value,
  output      logic        result_is_boolean,
  output      logic        overflow
);

  logic               en;
  logic               fr_valid;
  ckalu_pkg::side_t   fr_side;
  logic [63:0]        fr_dvd, fr_dvs;
  logic               pipe_valid;
  ckalu_pkg::result_t pipe_res;
  logic               skid_valid;
  ckalu_pkg::result_t skid_res;
  ckalu_pkg::result_t out_res;

  assign en        = ~skid_valid;
  assign req_stall = skid_valid;

  ckalu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (req_valid),
    .operation  (operation),
    .value_type (value_type),
    .lhs_value  (lhs_value),
    .rhs_value  (rhs_value),
    .out_valid  (fr_valid),
    .out_side   (fr_side),
    .out_dvd    (fr_dvd),
    .out_dvs    (fr_dvs)
  );

  ckalu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .in_dvd    (fr_dvd),
    .in_dvs    (fr_dvs),
    .out_valid (pipe_valid),
    .out_res   (pipe_res)
  );

  // output register with a one-entry skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      if (skid_valid) begin
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        rsp_valid <= pipe_valid;
      end
    end else if (pipe_valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || !rsp_stall) begin
      out_res <= skid_valid ? skid_res : pipe_res;
    end else if (pipe_valid && en) begin
      skid_res <= pipe_res;
    end
  end

  assign folded            = out_res.folded;
  assign result_value      = out_res.value;
  assign result_is_boolean = out_res.is_bool;
  assign overflow          = out_res.ovf;

  `CKALU_ASSERT_NOW(a_skid_behind_out, skid_valid, rsp_valid, "skid holds data with output empty")
  `CKALU_ASSERT_NEXT(a_skid_drains, skid_valid && !rsp_stall, rsp_valid && !skid_valid, "skid entry lost on drain")
  `CKALU_ASSERT_NOW(a_ovf_not_folded, rsp_valid && overflow, !folded, "overflow reported on folded result")
  `CKALU_ASSERT_NOW(a_bool_range, rsp_valid && folded && result_is_boolean, result_value[63:1] == 63'd0, "boolean result not 0 or 1")

endmodule

`default_nettype wire

// ===== src/ckalu_front.sv =====
// ----------------------------------------------------------------------------
// ckalu_front
// Four register stages: operand extension, compare / logic / add / partial
// products, product sum, product range check and result selection.
// ----------------------------------------------------------------------------
`default_nettype none

module ckalu_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [3:0]         operation,
  input  wire logic [2:0]         value_type,
  input  wire logic [63:0]        lhs_value,
  input  wire logic [63:0]        rhs_value,
  output      logic               out_valid,
  output      ckalu_pkg::side_t   out_side,
  output      logic [63:0]        out_dvd,
  output      logic [63:0]        out_dvs
);

  // stage 1: extended operands and magnitudes
  logic        v1;
  logic [3:0]  op1;
  logic [2:0]  ty1;
  logic [63:0] a1, b1, am1, bm1;
  logic        a_min1, b_min1;

  logic [63:0] a_ext, b_ext;
  assign a_ext = ckalu_pkg::sext(lhs_value, value_type);
  assign b_ext = ckalu_pkg::sext(rhs_value, value_type);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1    <= operation;
      ty1    <= value_type;
      a1     <= a_ext;
      b1     <= b_ext;
      am1    <= a_ext[63] ? (~a_ext + 64'd1) : a_ext;
      bm1    <= b_ext[63] ? (~b_ext + 64'd1) : b_ext;
      a_min1 <= (a_ext == ckalu_pkg::min_of(value_type));
      b_min1 <= (b_ext == ckalu_pkg::min_of(value_type));
    end
  end

  // stage 2: compare, logic, add / subtract, operand checks and partial products
  logic             cmp;
  logic [64:0]      sum, dif;
  ckalu_pkg::side_t side2_next;
  logic             mul_go_next;

  assign sum = {a1[63], a1} + {b1[63], b1};
  assign dif = {a1[63], a1} - {b1[63], b1};

  always_comb begin
    case (op1)
      ckalu_pkg::OP_EQ: cmp = (a1 == b1);
      ckalu_pkg::OP_NE: cmp = (a1 != b1);
      ckalu_pkg::OP_LT: cmp = ($signed(a1) <  $signed(b1));
      ckalu_pkg::OP_LE: cmp = ($signed(a1) <= $signed(b1));
      ckalu_pkg::OP_GT: cmp = ($signed(a1) >  $signed(b1));
      ckalu_pkg::OP_GE: cmp = ($signed(a1) >= $signed(b1));
      default:          cmp = 1'b0;
    endcase
  end

  always_comb begin
    side2_next         = '0;
    side2_next.is_bool = (ty1 == ckalu_pkg::TY_BOOL);
    side2_next.q_neg   = a1[63] ^ b1[63];
    mul_go_next        = 1'b0;
    if (ty1 == ckalu_pkg::TY_BOOL) begin
      case (op1)
        ckalu_pkg::OP_AND: begin
          side2_next.folded = 1'b1;
          side2_next.value  = {63'b0, a1[0] & b1[0]};
        end
        ckalu_pkg::OP_OR: begin
          side2_next.folded = 1'b1;
          side2_next.value  = {63'b0, a1[0] | b1[0]};
        end
        ckalu_pkg::OP_NOT: begin
          side2_next.folded = 1'b1;
          side2_next.value  = {63'b0, ~a1[0]};
        end
        default: begin
          if (op1 <= ckalu_pkg::OP_GE) begin
            side2_next.folded = 1'b1;
            side2_next.value  = {63'b0, cmp};
          end
        end
      endcase
    end else if (ty1 inside {[ckalu_pkg::TY_I8:ckalu_pkg::TY_I64]}) begin
      if (op1 <= ckalu_pkg::OP_GE) begin
        side2_next.folded  = 1'b1;
        side2_next.is_bool = 1'b1;
        side2_next.value   = {63'b0, cmp};
      end else begin
        case (op1)
          ckalu_pkg::OP_ADD: begin
            if (ckalu_pkg::fits({{63{sum[64]}}, sum}, ty1)) begin
              side2_next.folded = 1'b1;
              side2_next.value  = sum[63:0];
            end else begin
              side2_next.ovf = 1'b1;
            end
          end
          ckalu_pkg::OP_SUB: begin
            if (ckalu_pkg::fits({{63{dif[64]}}, dif}, ty1)) begin
              side2_next.folded = 1'b1;
              side2_next.value  = dif[63:0];
            end else begin
              side2_next.ovf = 1'b1;
            end
          end
          ckalu_pkg::OP_MUL: begin
            if (b1 == 64'd0) begin
              side2_next.folded = 1'b1;
            end else if (b1[63] && (a_min1 || b_min1)) begin
              side2_next.ovf = 1'b1;
            end else begin
              mul_go_next = 1'b1;
            end
          end
          ckalu_pkg::OP_DIV: begin
            if (b1 == 64'd0) begin
              side2_next.ovf = 1'b0;
            end else if (a_min1 && (b1 == {64{1'b1}})) begin
              side2_next.ovf = 1'b1;
            end else begin
              side2_next.div_go = 1'b1;
            end
          end
          default: side2_next.folded = 1'b0;
        endcase
      end
    end
  end

  logic             v2, mul_go2;
  ckalu_pkg::side_t side2;
  logic [2:0]       ty2;
  logic [63:0]      pp0, pp1, pp2, pp3;
  logic [63:0]      am2, bm2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2   <= side2_next;
      mul_go2 <= mul_go_next;
      ty2     <= ty1;
      pp0     <= am1[31:0]  * bm1[31:0];
      pp1     <= am1[31:0]  * bm1[63:32];
      pp2     <= am1[63:32] * bm1[31:0];
      pp3     <= am1[63:32] * bm1[63:32];
      am2     <= am1;
      bm2     <= bm1;
    end
  end

  // stage 3: product magnitude
  logic             v3, mul_go3;
  ckalu_pkg::side_t side3;
  logic [2:0]       ty3;
  logic [127:0]     mag3;
  logic [63:0]      am3, bm3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3   <= side2;
      mul_go3 <= mul_go2;
      ty3     <= ty2;
      mag3    <= {64'b0, pp0} + {32'b0, pp1, 32'b0} + {32'b0, pp2, 32'b0}
                 + {pp3, 64'b0};
      am3     <= am2;
      bm3     <= bm2;
    end
  end

  // stage 4: signed product, range check
  logic [127:0]     prod;
  logic             prod_fits;
  ckalu_pkg::side_t side4_next;

  assign prod      = side3.q_neg ? (~mag3 + 128'd1) : mag3;
  assign prod_fits = ckalu_pkg::fits(prod, ty3);

  always_comb begin
    side4_next = side3;
    if (mul_go3) begin
      side4_next.folded = prod_fits;
      side4_next.ovf    = ~prod_fits;
      side4_next.value  = prod_fits ? prod[63:0] : 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side4_next;
      out_dvd  <= am3;
      out_dvs  <= bm3;
    end
  end

endmodule

`default_nettype wire

// ===== src/ckalu_div.sv =====
// ----------------------------------------------------------------------------
// ckalu_div
// Restoring divider, one quotient bit per register stage, then sign fix-up
// and final result selection.
// ----------------------------------------------------------------------------
`default_nettype none

module ckalu_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire ckalu_pkg::side_t   in_side,
  input  wire logic [63:0]        in_dvd,
  input  wire logic [63:0]        in_dvs,
  output      logic               out_valid,
  output      ckalu_pkg::result_t out_res
);

  ckalu_pkg::div_stage_t st [0:ckalu_pkg::DIV_STAGES];
  logic                  sv [0:ckalu_pkg::DIV_STAGES];

  assign st[0].side = in_side;
  assign st[0].rem  = 64'd0;
  assign st[0].dvd  = in_dvd;
  assign st[0].dvs  = in_dvs;
  assign sv[0]      = in_valid;

  for (genvar i = 0; i < ckalu_pkg::DIV_STAGES; i++) begin : g_step
    logic [64:0] trial, diff;
    logic        take;

    assign trial = {st[i].rem, st[i].dvd[63]};
    assign diff  = trial - {1'b0, st[i].dvs};
    assign take  = ~diff[64];

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i+1] <= 1'b0;
      end else if (en) begin
        sv[i+1] <= sv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1].side <= st[i].side;
        st[i+1].dvs  <= st[i].dvs;
        st[i+1].rem  <= take ? diff[63:0] : trial[63:0];
        st[i+1].dvd  <= {st[i].dvd[62:0], take};
      end
    end
  end

  // quotient magnitude is at most 2^(w-1), so the negated word is already
  // sign-extended from the type width
  ckalu_pkg::div_stage_t last;
  ckalu_pkg::result_t    res_next;

  assign last = st[ckalu_pkg::DIV_STAGES];

  always_comb begin
    res_next.folded  = last.side.folded | last.side.div_go;
    res_next.is_bool = last.side.is_bool;
    res_next.ovf     = last.side.ovf;
    if (last.side.div_go) begin
      res_next.value = last.side.q_neg ? (~last.dvd + 64'd1) : last.dvd;
    end else begin
      res_next.value = last.side.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sv[ckalu_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= res_next;
    end
  end

endmodule

`default_nettype wire
